[src/fis_pkg.sv]
// Package for the free interval set: request and response transaction types,
// request and status codes, and the default table depth. No dependencies.
package fis_pkg;

    localparam int MaxRangesDef = 64;

    localparam logic [1:0] REQ_RELEASE = 2'd0;
    localparam logic [1:0] REQ_RESERVE = 2'd1;
    localparam logic [1:0] REQ_FIND    = 2'd2;
    localparam logic [1:0] REQ_LIST    = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] range_start;
        logic signed [31:0] range_end;
        logic [30:0]        request_length;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic signed [31:0] result_start;
        logic signed [31:0] result_end;
        logic               last;
        logic [6:0]         range_count;
        logic [31:0]        total_free;
    } t_rsp;

    // One stored free range [r_start, r_end)
    typedef struct packed {
        logic signed [31:0] r_start;
        logic signed [31:0] r_end;
    } t_range;

endpackage

[src/free_interval_set.sv]
// Free interval set: sorted table of disjoint free ranges in one memory,
// scanned and shifted by a sequencer. Depends on fis_pkg.
// Each entry scanned is read, then evaluated; release and reserve then move the entries
// above the run, write the new entries and commit, and a response may wait for ready.
// One request at a time; the memory read port sets the pace, and the next request is
// taken once the last response is loaded.
// Reset (synchronous, active low) empties the table at once: count and sum clear.
module free_interval_set
    import fis_pkg::*;
#(
    parameter int MAX_RANGES = MaxRangesDef
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    localparam int AW = $clog2(MAX_RANGES);
    localparam int CW = $clog2(MAX_RANGES + 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_RD   = 8'b0000_0010,
        S_EV   = 8'b0000_0100,
        S_END  = 8'b0000_1000,
        S_SHR  = 8'b0001_0000,
        S_SHW  = 8'b0010_0000,
        S_MID  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    // Range table
    t_range mem [MAX_RANGES];
    t_range r_rd;

    t_state  r_state, n_state;
    t_req    r_req, n_req;
    logic [CW-1:0] r_cnt, n_cnt, r_idx, n_idx, r_lo, n_lo, r_src, n_src, r_d, n_d;
    logic [CW-1:0] r_newcnt, n_newcnt;
    logic [31:0]   r_sum, n_sum, r_rem, n_rem, r_newsum, n_newsum;
    logic          r_lo_set, n_lo_set, r_ov, n_ov, r_pend, n_pend, r_dir, n_dir;
    logic signed [31:0] r_first_s, n_first_s, r_last_e, n_last_e;
    t_range        r_pend_rng, n_pend_rng, r_m0, n_m0, r_m1, n_m1;
    logic [1:0]    r_nmid, n_nmid, r_midi, n_midi;
    logic [1:0]    r_status, n_status;
    logic          r_found, n_found;
    logic signed [31:0] r_rs, n_rs, r_re, n_re;
    logic          r_o_valid, n_o_valid;
    t_rsp          r_out, n_out;

    // Memory port controls
    logic          rd_en, we;
    logic [AW-1:0] raddr, waddr;
    t_range        wdata;

    // Helpers for the scan and the plan
    logic          out_free;
    logic signed [32:0] room;
    logic [CW-1:0] lo_eff, k_ov;
    logic [CW:0]   new_m;
    logic          left_keep, right_keep;
    logic signed [31:0] ms, me;
    logic [31:0]   added;

    assign out_free    = !r_o_valid || i_rsp_ready;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_o_valid;
    assign o_rsp       = r_out;

    always_comb begin
        n_state = r_state;  n_req = r_req;      n_cnt = r_cnt;      n_idx = r_idx;
        n_lo = r_lo;        n_src = r_src;      n_d = r_d;          n_newcnt = r_newcnt;
        n_sum = r_sum;      n_rem = r_rem;      n_newsum = r_newsum;
        n_lo_set = r_lo_set; n_ov = r_ov;       n_pend = r_pend;    n_dir = r_dir;
        n_first_s = r_first_s; n_last_e = r_last_e; n_pend_rng = r_pend_rng;
        n_m0 = r_m0;        n_m1 = r_m1;        n_nmid = r_nmid;    n_midi = r_midi;
        n_status = r_status; n_found = r_found; n_rs = r_rs;        n_re = r_re;
        n_o_valid = r_o_valid && !i_rsp_ready;
        n_out = r_out;
        rd_en = 1'b0;  raddr = r_idx[AW-1:0];
        we = 1'b0;     waddr = r_src[AW-1:0];  wdata = r_rd;

        room   = 33'(signed'(r_rd.r_end)) - 33'(signed'(r_req.range_start));
        lo_eff = r_lo_set ? r_lo : r_idx;
        k_ov   = r_idx - lo_eff;
        left_keep  = r_ov && (r_first_s < r_req.range_start);
        right_keep = r_ov && (r_last_e > r_req.range_end);
        ms = left_keep  ? r_first_s : r_req.range_start;
        me = right_keep ? r_last_e  : r_req.range_end;
        added = 32'd0;
        new_m = '0;

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req = i_req;
                    n_idx = '0;  n_lo_set = 1'b0;  n_ov = 1'b0;  n_rem = 32'd0;
                    n_pend = 1'b0;
                    n_found = 1'b0;  n_rs = 32'sd0;  n_re = 32'sd0;
                    if (i_req.req_type != REQ_FIND && i_req.range_start >= i_req.range_end) begin
                        n_status = ST_EMPTY;
                        n_state  = S_DONE;
                    end else begin
                        n_status = ST_DONE;
                        n_state  = S_RD;
                    end
                end
            end
            // Issue the read of the next entry, or close the scan
            S_RD: begin
                if (r_idx == r_cnt) begin
                    n_state = S_END;
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_EV;
                end
            end
            // Classify the entry just read
            S_EV: begin
                if (r_rd.r_end <= r_req.range_start) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_RD;
                end else if (r_req.req_type == REQ_FIND) begin
                    if (r_rd.r_start <= r_req.range_start &&
                        room >= 33'(signed'({1'b0, r_req.request_length}))) begin
                        n_found = 1'b1;
                        n_rs = r_req.range_start;
                        n_re = r_req.range_start + signed'({1'b0, r_req.request_length});
                    end
                    n_state = S_DONE;
                end else if (r_rd.r_start < r_req.range_end) begin
                    // Overlap; a list holds one item back to learn its last flag
                    if (!(r_req.req_type == REQ_LIST && r_pend && !out_free)) begin
                        if (r_req.req_type == REQ_LIST && r_pend) begin
                            n_o_valid = 1'b1;
                            n_out = '{ST_DONE, 1'b1, r_pend_rng.r_start, r_pend_rng.r_end,
                                      1'b0, 7'(r_cnt), r_sum};
                        end
                        n_pend = (r_req.req_type == REQ_LIST);
                        n_pend_rng = r_rd;
                        if (!r_lo_set) begin
                            n_lo = r_idx;  n_lo_set = 1'b1;
                        end
                        if (!r_ov) n_first_s = r_rd.r_start;
                        n_ov = 1'b1;
                        n_last_e = r_rd.r_end;
                        n_rem = r_rem + 32'(r_rd.r_end - r_rd.r_start);
                        n_idx = r_idx + 1'b1;
                        n_state = S_RD;
                    end
                end else begin
                    if (!r_lo_set) begin
                        n_lo = r_idx;  n_lo_set = 1'b1;
                    end
                    n_state = S_END;
                end
            end
            // Scan is over: r_idx holds the end of the overlapping run
            S_END: begin
                if (r_req.req_type == REQ_FIND) begin
                    n_state = S_DONE;
                end else if (r_req.req_type == REQ_LIST) begin
                    if (!r_pend) begin
                        n_state = S_DONE;
                    end else if (out_free) begin
                        n_o_valid = 1'b1;
                        n_out = '{ST_DONE, 1'b1, r_pend_rng.r_start, r_pend_rng.r_end,
                                  1'b1, 7'(r_cnt), r_sum};
                        n_pend  = 1'b0;
                        n_state = S_IDLE;
                    end
                end else begin
                    if (r_req.req_type == REQ_RELEASE) begin
                        n_m0 = '{ms, me};
                        n_nmid = 2'd1;
                        added = 32'(me - ms);
                    end else begin
                        n_m0 = left_keep ? t_range'{r_first_s, r_req.range_start}
                                         : t_range'{r_req.range_end, r_last_e};
                        n_m1 = '{r_req.range_end, r_last_e};
                        n_nmid = 2'({1'b0, left_keep} + {1'b0, right_keep});
                        added = (left_keep ? 32'(r_req.range_start - r_first_s) : 32'd0)
                              + (right_keep ? 32'(r_last_e - r_req.range_end) : 32'd0);
                    end
                    new_m = (CW+1)'(lo_eff) + (CW+1)'(n_nmid) + (CW+1)'(r_cnt - r_idx);
                    n_newsum = r_sum - r_rem + added;
                    n_lo = lo_eff;
                    n_midi = 2'd0;
                    if (new_m > (CW+1)'(MAX_RANGES)) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_newcnt = new_m[CW-1:0];
                        if ((CW+1)'(n_nmid) > (CW+1)'(k_ov)) begin
                            n_dir = 1'b1;  n_src = r_cnt;
                        end else begin
                            n_dir = 1'b0;  n_src = r_idx;
                        end
                        n_d = k_ov - CW'(n_nmid);
                        n_state = S_SHR;
                    end
                end
            end
            // Move the entries above the run: up by one or down by r_d
            S_SHR: begin
                if (r_dir ? (r_src == r_idx) : (r_src == r_cnt)) begin
                    n_state = S_MID;
                end else begin
                    rd_en   = 1'b1;
                    raddr   = r_dir ? AW'(r_src - 1'b1) : r_src[AW-1:0];
                    n_state = S_SHW;
                end
            end
            S_SHW: begin
                we = 1'b1;
                if (r_dir) begin
                    waddr = r_src[AW-1:0];
                    n_src = r_src - 1'b1;
                end else begin
                    waddr = AW'(r_src - r_d);
                    n_src = r_src + 1'b1;
                end
                n_state = S_SHR;
            end
            // Write the merged or remainder entries, then commit
            S_MID: begin
                if (r_midi == r_nmid) begin
                    n_cnt   = r_newcnt;
                    n_sum   = r_newsum;
                    n_state = S_DONE;
                end else begin
                    we    = 1'b1;
                    waddr = AW'(r_lo + CW'(r_midi));
                    wdata = (r_midi == 2'd0) ? r_m0 : r_m1;
                    n_midi = r_midi + 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_out = '{r_status, r_found, r_rs, r_re, 1'b1, 7'(r_cnt), r_sum};
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        if (rd_en) r_rd <= mem[raddr];
    end

    // Hold control state under reset, advance otherwise
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_sum     <= 32'd0;
            r_o_valid <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_sum     <= n_sum;
            r_o_valid <= n_o_valid;
            r_pend    <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;      r_idx <= n_idx;       r_lo <= n_lo;        r_src <= n_src;
        r_d <= n_d;          r_newcnt <= n_newcnt; r_rem <= n_rem;      r_newsum <= n_newsum;
        r_lo_set <= n_lo_set; r_ov <= n_ov;        r_dir <= n_dir;
        r_first_s <= n_first_s; r_last_e <= n_last_e; r_pend_rng <= n_pend_rng;
        r_m0 <= n_m0;        r_m1 <= n_m1;         r_nmid <= n_nmid;    r_midi <= n_midi;
        r_status <= n_status; r_found <= n_found;  r_rs <= n_rs;        r_re <= n_re;
        r_out <= n_out;
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_RANGES))
        else $error("range count exceeds table depth");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> !o_req_ready)
        else $error("request taken while busy");
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend)
        else $error("list item left pending at idle");
    a_mid_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MID) |-> (r_lo <= r_cnt && r_newcnt <= CW'(MAX_RANGES)))
        else $error("insert position outside table");
`endif

endmodule

[tb/sv/free_interval_set_tb.sv]
// Testbench for free_interval_set: directed and random request streams checked
// against a behavioral free-range table model. Depends on fis_pkg and the DUT.
`timescale 1ns / 100ps

module free_interval_set_tb;
    import fis_pkg::*;

    localparam int Depth    = MaxRangesDef;
    localparam int IdleLim  = 20000;
    localparam int DrainLim = 4 * Depth + 40;
    localparam longint PosMin = -64'sd2147483648;
    localparam longint PosMax = 64'sd2147483647;

    logic i_clk;
    logic i_rst_n;
    logic i_req_valid;
    logic o_req_ready;
    t_req i_req;
    logic o_rsp_valid;
    logic i_rsp_ready;
    t_rsp o_rsp;

    free_interval_set #(.MAX_RANGES(Depth)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(i_req_valid), .o_req_ready(o_req_ready), .i_req(i_req),
        .o_rsp_valid(o_rsp_valid), .i_rsp_ready(i_rsp_ready), .o_rsp(o_rsp)
    );

    // Model state: sorted free ranges
    longint tbl_lo[$];
    longint tbl_hi[$];

    t_req  pending_reqs[$];
    t_rsp  expected_rsps[$];
    int    error_count;
    int    idle_cycles;
    bit    calm;         // no idling on either side
    bit    hold_sender;  // pause until every response is back

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Append to the expected and pending transaction queues
    task automatic queue_rsp(input t_rsp r);
        expected_rsps = {expected_rsps, r};
    endtask

    task automatic queue_req(input t_req q);
        pending_reqs = {pending_reqs, q};
    endtask

    function automatic t_rsp make_rsp(logic [1:0] st, logic fnd, longint rs, longint re,
                                      logic lst);
        t_rsp r;
        longint sum;
        sum = 0;
        foreach (tbl_lo[i]) sum += tbl_hi[i] - tbl_lo[i];
        r.status = st;
        r.found = fnd;
        r.result_start = rs[31:0];
        r.result_end = re[31:0];
        r.last = lst;
        r.range_count = 7'(tbl_lo.size());
        r.total_free = sum[31:0];
        return r;
    endfunction

    // Apply one request to the range table and queue its responses
    task automatic predict_ranges(input t_req q);
        longint s, e, len, ms, me;
        longint nlo[$], nhi[$];
        int n, lo, hi;
        s = q.range_start;
        e = q.range_end;
        len = q.request_length;
        n = tbl_lo.size();
        if (q.req_type == REQ_FIND) begin
            for (int i = 0; i < n; i++)
                if (tbl_lo[i] <= s && s < tbl_hi[i] && tbl_hi[i] - s >= len) begin
                    queue_rsp(make_rsp(ST_DONE, 1'b1, s, s + len, 1'b1));
                    return;
                end
            queue_rsp(make_rsp(ST_DONE, 1'b0, 0, 0, 1'b1));
            return;
        end
        if (s >= e) begin
            queue_rsp(make_rsp(ST_EMPTY, 1'b0, 0, 0, 1'b1));
            return;
        end
        lo = 0;
        while (lo < n && tbl_hi[lo] <= s) lo++;
        hi = lo;
        while (hi < n && tbl_lo[hi] < e) hi++;
        if (q.req_type == REQ_LIST) begin
            if (hi == lo) queue_rsp(make_rsp(ST_DONE, 1'b0, 0, 0, 1'b1));
            for (int i = lo; i < hi; i++)
                queue_rsp(make_rsp(ST_DONE, 1'b1, tbl_lo[i], tbl_hi[i], i + 1 == hi));
            return;
        end
        for (int i = 0; i < lo; i++) begin
            nlo = {nlo, tbl_lo[i]};
            nhi = {nhi, tbl_hi[i]};
        end
        if (q.req_type == REQ_RELEASE) begin
            ms = s;
            me = e;
            if (hi > lo) begin
                if (tbl_lo[lo] < ms) ms = tbl_lo[lo];
                if (tbl_hi[hi-1] > me) me = tbl_hi[hi-1];
            end
            nlo = {nlo, ms};
            nhi = {nhi, me};
        end else if (hi > lo) begin
            if (tbl_lo[lo] < s) begin
                nlo = {nlo, tbl_lo[lo]};
                nhi = {nhi, s};
            end
            if (tbl_hi[hi-1] > e) begin
                nlo = {nlo, e};
                nhi = {nhi, tbl_hi[hi-1]};
            end
        end
        for (int i = hi; i < n; i++) begin
            nlo = {nlo, tbl_lo[i]};
            nhi = {nhi, tbl_hi[i]};
        end
        if (nlo.size() > Depth) begin
            queue_rsp(make_rsp(ST_FULL, 1'b0, 0, 0, 1'b1));
            return;
        end
        tbl_lo = nlo;
        tbl_hi = nhi;
        queue_rsp(make_rsp(ST_DONE, 1'b0, 0, 0, 1'b1));
    endtask

    function automatic t_req mk(logic [1:0] op, longint s, longint e, longint len);
        t_req q;
        q.req_type = op;
        q.range_start = s[31:0];
        q.range_end = e[31:0];
        q.request_length = len[30:0];
        return q;
    endfunction

    // Random request in a small window so ranges interact; sometimes full scale.
    // Total free length stays below 2^32 since all positions sit in a signed 32-bit span.
    function automatic t_req rand_req(int mode);
        t_req q;
        longint base, s, w;
        logic [1:0] op;
        op = 2'($urandom_range(0, 3));
        if (mode == 0) begin
            base = $urandom_range(0, 3) == 0 ? -longint'(2000) : longint'(1000);
            s = base + $urandom_range(0, 1200);
            w = $urandom_range(0, 9) == 0 ? -longint'($urandom_range(0, 20))
                                          : longint'($urandom_range(1, 60));
            q = mk(op, s, s + w, $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 80));
        end else begin
            q.req_type = op;
            q.range_start = $urandom;
            q.range_end = $urandom;
            q.request_length = 31'($urandom);
        end
        return q;
    endfunction

    // Fill the request queue
    initial begin
        error_count = 0;
        calm = 1'b0;
        hold_sender = 1'b0;
        // extremes and every special case
        queue_req(mk(REQ_LIST, PosMin, PosMax, 0));
        queue_req(mk(REQ_FIND, 0, 0, 0));
        queue_req(mk(REQ_RELEASE, 5, 5, 0));
        queue_req(mk(REQ_RESERVE, 9, 3, 0));
        queue_req(mk(REQ_LIST, 7, -7, 0));
        queue_req(mk(REQ_RELEASE, PosMin, -2147483000, 0));
        queue_req(mk(REQ_RELEASE, 2147483000, PosMax, 0));
        queue_req(mk(REQ_RELEASE, 100, 200, 0));
        queue_req(mk(REQ_RELEASE, 200, 300, 0));
        queue_req(mk(REQ_RELEASE, 150, 250, 0));
        queue_req(mk(REQ_FIND, 100, 0, 300));
        queue_req(mk(REQ_FIND, 100, 0, 301));
        queue_req(mk(REQ_FIND, 2147483000, 0, 647));
        queue_req(mk(REQ_FIND, 50, 0, 0));
        queue_req(mk(REQ_RESERVE, 120, 130, 0));
        queue_req(mk(REQ_RESERVE, 90, 110, 0));
        queue_req(mk(REQ_RESERVE, 290, 400, 0));
        queue_req(mk(REQ_LIST, PosMin, PosMax, 0));
        queue_req(mk(REQ_FIND, 115, 0, PosMax));
        queue_req(mk(REQ_RESERVE, PosMin, PosMax, 0));
        queue_req(mk(REQ_LIST, 0, 1, 0));
        // fill the table to its limit, then push past it
        for (int i = 0; i < Depth; i++) queue_req(mk(REQ_RELEASE, 4*i, 4*i + 2, 0));
        queue_req(mk(REQ_RELEASE, 1000, 1001, 0));
        queue_req(mk(REQ_RESERVE, 0, 1, 0));
        queue_req(mk(REQ_LIST, -5, 1000, 0));
        queue_req(mk(REQ_RELEASE, 1, 250, 0));
        queue_req(mk(REQ_RESERVE, PosMin, PosMax, 0));
        for (int i = 0; i < 370; i++)
            queue_req(rand_req($urandom_range(0, 19) == 0));
    end

    // Reset, pressure pause, calm stretch, then drain
    initial begin
        int drain;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_reqs.size() < 300);
        @(posedge i_clk);
        hold_sender = 1'b1;
        wait (expected_rsps.size() == 0 && !i_req_valid);
        @(posedge i_clk);
        hold_sender = 1'b0;
        calm = 1'b1;
        wait (pending_reqs.size() < 200);
        calm = 1'b0;
        wait (pending_reqs.size() == 0 && !i_req_valid && expected_rsps.size() == 0);
        drain = 0;
        while (drain < DrainLim) begin
            @(posedge i_clk);
            drain++;
        end
        if (error_count == 0 && expected_rsps.size() == 0)
            $display("free_interval_set_tb: clean");
        else
            $display("free_interval_set_tb: errors");
        $finish;
    end

    // Driver: present the next request, hold until accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
            i_req <= '0;
        end else if (!i_req_valid || o_req_ready) begin
            if (i_req_valid) predict_ranges(i_req);
            if (pending_reqs.size() > 0 && !hold_sender && (calm || $urandom_range(0, 99) >= 33))
            begin
                i_req <= pending_reqs.pop_front();
                i_req_valid <= 1'b1;
            end else begin
                i_req_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted response, throttle ready
    always @(posedge i_clk) begin
        t_rsp w;
        if (!i_rst_n) begin
            i_rsp_ready <= 1'b0;
            idle_cycles <= 0;
        end else begin
            if (o_rsp_valid && i_rsp_ready) begin
                if (expected_rsps.size() == 0) begin
                    report_mismatch("unexpected response", 1, 0);
                end else begin
                    w = expected_rsps.pop_front();
                    if (o_rsp.status != w.status) report_mismatch("status", o_rsp.status, w.status);
                    if (o_rsp.found != w.found) report_mismatch("found", o_rsp.found, w.found);
                    if (o_rsp.result_start != w.result_start)
                        report_mismatch("result_start", o_rsp.result_start, w.result_start);
                    if (o_rsp.result_end != w.result_end)
                        report_mismatch("result_end", o_rsp.result_end, w.result_end);
                    if (o_rsp.last != w.last) report_mismatch("last", o_rsp.last, w.last);
                    if (o_rsp.range_count != w.range_count)
                        report_mismatch("range_count", o_rsp.range_count, w.range_count);
                    if (o_rsp.total_free != w.total_free)
                        report_mismatch("total_free", o_rsp.total_free, w.total_free);
                end
            end
            i_rsp_ready <= calm || $urandom_range(0, 99) >= 33;
            // watchdog on cycles with no transaction
            if ((o_rsp_valid && i_rsp_ready) || (i_req_valid && o_req_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IdleLim) begin
                $display("free_interval_set_tb: errors");
                $finish;
            end else
                idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
